FILE: hw/rtl/krc_pkg.sv
// ----------------------------------------------------------------------------
// krc_pkg
// Shared types and constants for the keyed result cache: table geometry,
// operation and status codes, and the layout of one table entry.
// ----------------------------------------------------------------------------
package krc_pkg;

   localparam int ENTRIES         = 8;
   localparam int RESULT_MAX_SIZE = 1024;
   localparam int IDENTITY_BYTES  = 32;

   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LEN_W     = $clog2(RESULT_MAX_SIZE);
   localparam int LEN_OUT_W = 10;
   localparam int SEQ_W     = 32;
   localparam int KEY_W     = 64;

   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   // operation codes
   localparam logic [2:0] OP_STORE         = 3'd0;
   localparam logic [2:0] OP_RETRY_LOOKUP  = 3'd1;
   localparam logic [2:0] OP_LOOKUP        = 3'd2;
   localparam logic [2:0] OP_ACK           = 3'd3;
   localparam logic [2:0] OP_CLEAR_SESSION = 3'd4;
   localparam logic [2:0] OP_CLEAR_ALL     = 3'd5;

   // status codes
   localparam logic [2:0] RSP_OK        = 3'd0;
   localparam logic [2:0] RSP_DUPLICATE = 3'd1;
   localparam logic [2:0] RSP_CONFLICT  = 3'd2;
   localparam logic [2:0] RSP_TOO_LARGE = 3'd3;
   localparam logic [2:0] RSP_INVALID   = 3'd4;
   localparam logic [2:0] RSP_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic [KEY_W-1:0] session;
      logic [KEY_W-1:0] request;
      logic [KEY_W-1:0] identity;
      logic [KEY_W-1:0] payload;
      logic [LEN_W-1:0] length;
      logic [SEQ_W-1:0] seq_num;
   } entry_type;

endpackage

FILE: hw/rtl/keyed_result_cache_fifo_evict.sv
// ----------------------------------------------------------------------------
// keyed_result_cache_fifo_evict
// Table of cached results keyed by session and request key, with
// oldest-first eviction, served by one entry comparator under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one operation (store, retry lookup, lookup, acknowledge,
//    clear session, clear all) with its keys and arguments; rsp_* returns
//    exactly one status, payload handle and length per transaction.
//  - Both channels use valid/ready; a transaction moves when both are high.
//  - Store, lookups, acknowledge and clear session scan the table entry by
//    entry (registered read of the entry memory, then one pass through the
//    shared key/sequence comparator), then pass an update step and a finish
//    step that loads the response register; the sequencer returns to idle
//    in the same cycle that the response becomes valid.
//  - Clear all, unknown operations and requests that fail argument checks
//    skip the scan and go straight to the finish step.
//  - One transaction is in flight at a time; req_ready is high while the
//    sequencer is idle, also while an earlier response waits on rsp_ready.
//  - If the receiver stalls, the finished result holds in the sequencer
//    until the response register frees up.
//  - Reset marks every entry empty and clears the insertion counter; the
//    block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module keyed_result_cache_fifo_evict
   import krc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_operation,
   input  logic [KEY_W-1:0]     req_session_key,
   input  logic [KEY_W-1:0]     req_request_key,
   input  logic [KEY_W-1:0]     req_identity_word,
   input  logic [7:0]           req_identity_length,
   input  logic [KEY_W-1:0]     req_payload_word,
   input  logic [11:0]          req_payload_length,
   input  logic [11:0]          req_reader_capacity,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [KEY_W-1:0]     rsp_payload_out,
   output logic [LEN_OUT_W-1:0] rsp_length_out
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_UPDATE,
      S_FINISH
   } state_type;

   state_type            state_ff;
   logic [ENTRIES-1:0]   valid_ff;
   logic [SEQ_W-1:0]     insert_cnt_ff;
   logic [IDX_W-1:0]     idx_ff;

   // captured transaction
   logic [2:0]           op_ff;
   logic [KEY_W-1:0]     session_ff;
   logic [KEY_W-1:0]     request_ff;
   logic [KEY_W-1:0]     identity_ff;
   logic [KEY_W-1:0]     payload_ff;
   logic [LEN_W-1:0]     plen_ff;
   logic [11:0]          cap_ff;

   // scan results
   logic                 match_found_ff;
   logic [IDX_W-1:0]     match_idx_ff;
   logic [KEY_W-1:0]     match_identity_ff;
   logic [KEY_W-1:0]     match_payload_ff;
   logic [LEN_W-1:0]     match_length_ff;
   logic                 free_found_ff;
   logic [IDX_W-1:0]     free_idx_ff;
   logic                 oldest_found_ff;
   logic [IDX_W-1:0]     oldest_idx_ff;
   logic [SEQ_W-1:0]     oldest_ff;

   // finished result and response register
   logic [2:0]           res_status_ff;
   logic [KEY_W-1:0]     res_payload_ff;
   logic [LEN_W-1:0]     res_length_ff;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [KEY_W-1:0]     rsp_payload_ff;
   logic [LEN_OUT_W-1:0] rsp_length_ff;

   // entry memory
   entry_type            entry_mem [ENTRIES];
   entry_type            rd_entry_ff;
   entry_type            wr_entry;
   logic                 mem_we;
   logic [IDX_W-1:0]     wr_idx;

   logic                 req_fire;
   logic                 key_eq;
   logic                 session_eq;
   logic                 seq_lt;
   logic                 last_idx;
   logic                 store_bad_arg;
   logic                 store_bad_len;
   state_type            start_state;
   logic [2:0]           start_status;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign rsp_length_out  = rsp_length_ff;

   assign store_bad_arg = (req_session_key == '0) || (req_request_key == '0) ||
                          (req_identity_length != 8'(IDENTITY_BYTES));
   assign store_bad_len = (req_payload_length == '0) ||
                          ({1'b0, req_payload_length} >= 13'(RESULT_MAX_SIZE));

   // first step and early status of an accepted transaction
   always_comb begin
      start_state  = S_READ;
      start_status = RSP_OK;
      case (req_operation)
         OP_STORE: begin
            if (store_bad_arg) begin
               start_status = RSP_INVALID;
               start_state  = S_FINISH;
            end else if (store_bad_len) begin
               start_status = RSP_TOO_LARGE;
               start_state  = S_FINISH;
            end
         end
         OP_RETRY_LOOKUP: begin
            if (req_identity_length != 8'(IDENTITY_BYTES) ||
                req_reader_capacity == '0) begin
               start_status = RSP_INVALID;
               start_state  = S_FINISH;
            end
         end
         OP_LOOKUP: begin
            if (req_reader_capacity == '0) begin
               start_status = RSP_INVALID;
               start_state  = S_FINISH;
            end
         end
         OP_ACK, OP_CLEAR_SESSION: begin
         end
         OP_CLEAR_ALL: begin
            start_state = S_FINISH;
         end
         default: begin
            start_status = RSP_INVALID;
            start_state  = S_FINISH;
         end
      endcase
   end

   // shared entry comparator
   assign session_eq = (rd_entry_ff.session == session_ff);
   assign key_eq     = session_eq && (rd_entry_ff.request == request_ff);
   assign seq_lt     = (rd_entry_ff.seq_num < oldest_ff);
   assign last_idx   = (idx_ff == IDX_W'(ENTRIES - 1));

   // store target: first free slot, else lowest sequence, else slot zero
   always_comb begin
      if (free_found_ff) begin
         wr_idx = free_idx_ff;
      end else if (oldest_found_ff) begin
         wr_idx = oldest_idx_ff;
      end else begin
         wr_idx = '0;
      end
      wr_entry.session  = session_ff;
      wr_entry.request  = request_ff;
      wr_entry.identity = identity_ff;
      wr_entry.payload  = payload_ff;
      wr_entry.length   = plen_ff;
      wr_entry.seq_num  = insert_cnt_ff + SEQ_W'(1);
      mem_we = (state_ff == S_UPDATE) && (op_ff == OP_STORE) && !match_found_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_idx] <= wr_entry;
      end
      if (state_ff == S_READ) begin
         rd_entry_ff <= entry_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         insert_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff           <= req_operation;
                  session_ff      <= req_session_key;
                  request_ff      <= req_request_key;
                  identity_ff     <= req_identity_word;
                  payload_ff      <= req_payload_word;
                  plen_ff         <= LEN_W'(req_payload_length);
                  cap_ff          <= req_reader_capacity;
                  idx_ff          <= '0;
                  match_found_ff  <= 1'b0;
                  free_found_ff   <= 1'b0;
                  oldest_found_ff <= 1'b0;
                  oldest_ff       <= SEQ_MAX;
                  res_payload_ff  <= '0;
                  res_length_ff   <= '0;
                  res_status_ff   <= start_status;
                  state_ff        <= start_state;
                  if (req_operation == OP_CLEAR_ALL) begin
                     valid_ff <= '0;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (!match_found_ff && valid_ff[idx_ff] && key_eq) begin
                  match_found_ff    <= 1'b1;
                  match_idx_ff      <= idx_ff;
                  match_identity_ff <= rd_entry_ff.identity;
                  match_payload_ff  <= rd_entry_ff.payload;
                  match_length_ff   <= rd_entry_ff.length;
               end
               if (!free_found_ff && !valid_ff[idx_ff]) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= idx_ff;
               end
               if (seq_lt) begin
                  oldest_found_ff <= 1'b1;
                  oldest_idx_ff   <= idx_ff;
                  oldest_ff       <= rd_entry_ff.seq_num;
               end
               if (op_ff == OP_CLEAR_SESSION && valid_ff[idx_ff] && session_eq) begin
                  valid_ff[idx_ff] <= 1'b0;
               end
               if (last_idx) begin
                  state_ff <= S_UPDATE;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= S_READ;
               end
            end
            S_UPDATE: begin
               state_ff <= S_FINISH;
               case (op_ff)
                  OP_STORE: begin
                     if (match_found_ff) begin
                        res_status_ff <= (match_identity_ff == identity_ff) ?
                                         RSP_DUPLICATE : RSP_CONFLICT;
                     end else begin
                        valid_ff[wr_idx] <= 1'b1;
                        insert_cnt_ff    <= wr_entry.seq_num;
                        res_status_ff    <= RSP_OK;
                     end
                  end
                  OP_RETRY_LOOKUP, OP_LOOKUP: begin
                     if (!match_found_ff) begin
                        res_status_ff <= RSP_NOT_FOUND;
                     end else if (op_ff == OP_RETRY_LOOKUP &&
                                  match_identity_ff != identity_ff) begin
                        res_status_ff <= RSP_CONFLICT;
                     end else if (12'(match_length_ff) >= cap_ff) begin
                        res_status_ff <= RSP_INVALID;
                     end else begin
                        res_status_ff  <= RSP_OK;
                        res_payload_ff <= match_payload_ff;
                        res_length_ff  <= match_length_ff;
                     end
                  end
                  OP_ACK: begin
                     if (match_found_ff) begin
                        valid_ff[match_idx_ff] <= 1'b0;
                        res_status_ff          <= RSP_OK;
                     end else begin
                        res_status_ff <= RSP_NOT_FOUND;
                     end
                  end
                  default: begin
                     res_status_ff <= RSP_OK;
                  end
               endcase
            end
            S_FINISH: begin
               // hand over once the response register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_payload_ff <= res_payload_ff;
                  rsp_length_ff  <= LEN_OUT_W'(res_length_ff);
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("response raised outside finish state");

   a_clear_all_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_operation == OP_CLEAR_ALL) |=> (valid_ff == '0))
      else $error("clear all left valid entries");

   a_fail_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != RSP_OK) |->
         (rsp_payload_ff == '0 && rsp_length_ff == '0))
      else $error("failed transaction carries payload");

   a_store_write_target: assert property (@(posedge clock) disable iff (reset)
      (mem_we && free_found_ff) |-> !valid_ff[wr_idx])
      else $error("store overwrote a valid entry while a free slot existed");

endmodule
